// File: hw/rtl/tosd_pkg.sv
// ----------------------------------------------------------------------------
// tosd_pkg
// Shared types, register codes and reset values of the cable force block.
// ----------------------------------------------------------------------------
package tosd_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [30:0] REST_LENGTH_RST = 31'd144179;
    localparam logic [30:0] STIFFNESS_RST   = 31'd3276800;
    localparam logic [30:0] DAMPING_RST     = 31'd1966080;
    localparam logic        ENABLE_RST      = 1'b1;

    typedef enum logic [7:0] {
        REG_REST_LENGTH = 8'd0,
        REG_STIFFNESS   = 8'd1,
        REG_DAMPING     = 8'd2,
        REG_ENABLE      = 8'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] pos_a_z;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] pos_b_z;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_a_z;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic signed [31:0] vel_b_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] force_a_x;
        logic signed [31:0] force_a_y;
        logic signed [31:0] force_a_z;
        logic [30:0]        tension;
        logic               taut;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] wdata;
    } cfg_item_t;

    // per-item data carried alongside the length and divide pipelines
    typedef struct packed {
        logic [2:0][31:0]        dm;   // |delta| per axis
        logic [2:0]              ds;   // delta sign per axis
        logic [2:0][32:0]        dv;   // velocity difference per axis
    } carry_t;

endpackage

// File: hw/rtl/tosd_in_if.sv
// ----------------------------------------------------------------------------
// tosd_in_if
// Input item channel: valid, ready and one cable end-point pair.
// ----------------------------------------------------------------------------
interface tosd_in_if;
    import tosd_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tosd_out_if.sv
// ----------------------------------------------------------------------------
// tosd_out_if
// Result channel: valid, ready and one force result.
// ----------------------------------------------------------------------------
interface tosd_out_if;
    import tosd_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tosd_cfg_if.sv
// ----------------------------------------------------------------------------
// tosd_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface tosd_cfg_if;
    import tosd_pkg::*;
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tension_only_spring_damper_force.sv
// ----------------------------------------------------------------------------
// tension_only_spring_damper_force
// Tension-only spring-damper cable: length by pipelined square root,
// unit vector by pipelined restoring divide, then tension and force.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                handshake
//  in_ch    in   pos_a/pos_b/vel_a/vel_b x,y,z (s32)    valid/ready
//  out_ch   out  force_a x,y,z (s32), tension, taut     valid/ready
//  cfg_ch   in   idx (8b), wdata (32b)                  valid/ready (always ready)
//
// One item per cycle while the output is not stalled; 3 front stages, 34 root
// stages (one result bit each), 1 compare stage, FRAC_BITS + 1 divide stages
// and 6 multiply/sum/saturate stages.
// Reset clears valid bits and loads register reset values.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage.
// ----------------------------------------------------------------------------
module tension_only_spring_damper_force #(
    parameter int FRAC_BITS = tosd_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tosd_in_if.sink   in_ch,
    tosd_out_if.source out_ch,
    tosd_cfg_if.sink  cfg_ch
);
    import tosd_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int NSQ   = 34;          // root bits
    localparam int QW    = F + 1;       // quotient bits
    localparam int UW    = F + 2;       // signed unit width
    localparam int PW    = F + 35;      // dv * u
    localparam int SW    = F + 37;      // sum of three products
    localparam int RW    = 37;          // relative velocity
    localparam int SPW   = 65;          // stiffness * stretch
    localparam int SPS   = SPW - F;     // spring after shift
    localparam int DPW   = 69;          // damping * rel
    localparam int TW    = 71;          // tension sum
    localparam int FPW   = F + 34;      // u * tension

    // ---------------- configuration ----------------
    logic [30:0] rest_reg, stiff_reg, damp_reg;
    logic        enable_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg   <= REST_LENGTH_RST;
            stiff_reg  <= STIFFNESS_RST;
            damp_reg   <= DAMPING_RST;
            enable_reg <= ENABLE_RST;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.data.idx)
                REG_REST_LENGTH: rest_reg   <= cfg_ch.data.wdata[30:0];
                REG_STIFFNESS:   stiff_reg  <= cfg_ch.data.wdata[30:0];
                REG_DAMPING:     damp_reg   <= cfg_ch.data.wdata[30:0];
                REG_ENABLE:      enable_reg <= cfg_ch.data.wdata[0];
                default:         ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic out_vld_reg;
    logic adv;

    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // ---------------- stage A: differences ----------------
    logic             a_vld_reg;
    carry_t           a_c_reg;
    logic signed [31:0] pa [3], pb [3], va [3], vb [3];
    carry_t           a_c_next;

    always_comb
    begin
        pa[0] = in_ch.data.pos_a_x; pa[1] = in_ch.data.pos_a_y; pa[2] = in_ch.data.pos_a_z;
        pb[0] = in_ch.data.pos_b_x; pb[1] = in_ch.data.pos_b_y; pb[2] = in_ch.data.pos_b_z;
        va[0] = in_ch.data.vel_a_x; va[1] = in_ch.data.vel_a_y; va[2] = in_ch.data.vel_a_z;
        vb[0] = in_ch.data.vel_b_x; vb[1] = in_ch.data.vel_b_y; vb[2] = in_ch.data.vel_b_z;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [32:0] d;
            logic        [32:0] dn;
            d  = 33'(pb[i]) - 33'(pa[i]);
            dn = 33'(-d);
            a_c_next.ds[i] = d[32];
            a_c_next.dm[i] = d[32] ? dn[31:0] : d[31:0];
            a_c_next.dv[i] = 33'(vb[i]) - 33'(va[i]);
        end
    end

    // ---------------- stage B: squares ----------------
    logic        b_vld_reg;
    carry_t      b_c_reg;
    logic [63:0] b_sq_reg [3];

    // ---------------- root pipeline (index 0 is stage C) ----------------
    logic        sq_vld_reg  [0:NSQ];
    carry_t      sq_c_reg    [0:NSQ];
    logic [33:0] sq_root_reg [0:NSQ];
    logic [35:0] sq_rem_reg  [0:NSQ-1];
    logic [67:0] sq_s_reg    [0:NSQ-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg     <= in_ch.valid;
            b_vld_reg     <= a_vld_reg;
            sq_vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_c_reg <= a_c_next;
            b_c_reg <= a_c_reg;
            for (int i = 0; i < 3; i++)
                b_sq_reg[i] <= 64'(a_c_reg.dm[i]) * 64'(a_c_reg.dm[i]);
            sq_c_reg[0]    <= b_c_reg;
            sq_s_reg[0]    <= 68'(b_sq_reg[0]) + 68'(b_sq_reg[1]) + 68'(b_sq_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        logic [37:0] t, trial, diff;
        logic        ge;
        assign t     = {sq_rem_reg[k], sq_s_reg[k][67:66]};
        assign trial = {2'b00, sq_root_reg[k], 2'b01};
        assign ge    = t >= trial;
        assign diff  = t - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else if (adv)
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_c_reg[k+1]    <= sq_c_reg[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][32:0], ge};
            end
        end

        if (k < NSQ - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_rem_reg[k+1] <= ge ? diff[35:0] : t[35:0];
                    sq_s_reg[k+1]   <= {sq_s_reg[k][65:0], 2'b00};
                end
            end
        end
    end

    // ---------------- divide pipeline (index 0 is the compare stage) ----------------
    logic        dv_vld_reg  [0:QW];
    carry_t      dv_c_reg    [0:QW];
    logic [33:0] dv_len_reg  [0:QW];
    logic        dv_taut_reg [0:QW];
    logic [34:0] dv_rem_reg  [0:QW-1][3];
    logic [QW-1:0] dv_q_reg  [0:QW][3];

    logic [33:0] len_fin;
    assign len_fin = sq_root_reg[NSQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (adv)
            dv_vld_reg[0] <= sq_vld_reg[NSQ];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_c_reg[0]    <= sq_c_reg[NSQ];
            dv_len_reg[0]  <= len_fin;
            dv_taut_reg[0] <= enable_reg && (len_fin > 34'(rest_reg));
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= 35'(sq_c_reg[NSQ].dm[i][31:1]);
                dv_q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [35:0] t  [3];
        logic [35:0] df [3];
        logic        ge [3];
        for (genvar i = 0; i < 3; i++) begin : g_ax
            // only the first step shifts in a dividend bit; the rest are zero
            assign t[i]  = {dv_rem_reg[j][i], (j == 0) ? dv_c_reg[j].dm[i][0] : 1'b0};
            assign ge[i] = t[i] >= 36'(dv_len_reg[j]);
            assign df[i] = t[i] - 36'(dv_len_reg[j]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else if (adv)
                dv_vld_reg[j+1] <= dv_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_c_reg[j+1]    <= dv_c_reg[j];
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_taut_reg[j+1] <= dv_taut_reg[j];
                for (int i = 0; i < 3; i++)
                    dv_q_reg[j+1][i] <= {dv_q_reg[j][i][QW-2:0], ge[i]};
            end
        end

        if (j < QW - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                    for (int i = 0; i < 3; i++)
                        dv_rem_reg[j+1][i] <= ge[i] ? df[i][34:0] : t[i][34:0];
            end
        end
    end

    // ---------------- M1: unit, dv*u, spring product ----------------
    logic                  m1_vld_reg, m1_taut_reg;
    logic signed [UW-1:0]  m1_u_reg  [3];
    logic signed [PW-1:0]  m1_pr_reg [3];
    logic [SPW-1:0]        m1_sp_reg;
    logic signed [UW-1:0]  u_next [3];
    logic [33:0]           stretch;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [UW-1:0] up;
            up        = signed'({1'b0, dv_q_reg[QW][i]});
            u_next[i] = dv_c_reg[QW].ds[i] ? -up : up;
        end
        stretch = dv_len_reg[QW] - 34'(rest_reg);
    end

    // ---------------- M2: relative velocity, spring ----------------
    logic                  m2_vld_reg, m2_taut_reg;
    logic signed [UW-1:0]  m2_u_reg [3];
    logic signed [RW-1:0]  m2_rel_reg;
    logic [SPS-1:0]        m2_sp_reg;
    logic signed [SW-1:0]  rel_sum;

    assign rel_sum = SW'(m1_pr_reg[0]) + SW'(m1_pr_reg[1]) + SW'(m1_pr_reg[2]);

    // ---------------- M3: damping product ----------------
    logic                  m3_vld_reg, m3_taut_reg;
    logic signed [UW-1:0]  m3_u_reg [3];
    logic [SPS-1:0]        m3_sp_reg;
    logic signed [DPW-1:0] m3_dp_reg;

    // ---------------- M4: tension with clamp ----------------
    logic                  m4_vld_reg, m4_taut_reg;
    logic signed [UW-1:0]  m4_u_reg [3];
    logic [30:0]           m4_t_reg;
    logic signed [TW-1:0]  t_sum;
    logic signed [DPW-F-1:0] dp_sh;
    logic [30:0]           t_next;

    assign dp_sh = m3_dp_reg[DPW-1:F];
    assign t_sum = TW'(signed'({1'b0, m3_sp_reg})) + TW'(dp_sh);

    always_comb
    begin
        if (!m3_taut_reg || t_sum <= 0)
            t_next = '0;
        else if (t_sum > TW'(32'h7FFF_FFFF))
            t_next = 31'h7FFF_FFFF;
        else
            t_next = t_sum[30:0];
    end

    // ---------------- M5: force products ----------------
    logic                  m5_vld_reg, m5_taut_reg;
    logic [30:0]           m5_t_reg;
    logic signed [FPW-1:0] m5_fp_reg [3];

    // ---------------- output register ----------------
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            m4_vld_reg  <= 1'b0;
            m5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg  <= dv_vld_reg[QW];
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            m4_vld_reg  <= m3_vld_reg;
            m5_vld_reg  <= m4_vld_reg;
            out_vld_reg <= m5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_taut_reg <= dv_taut_reg[QW];
            m1_sp_reg   <= SPW'(stiff_reg) * SPW'(stretch);
            for (int i = 0; i < 3; i++)
            begin
                m1_u_reg[i]  <= u_next[i];
                m1_pr_reg[i] <= PW'(signed'(dv_c_reg[QW].dv[i])) * PW'(u_next[i]);
            end

            m2_taut_reg <= m1_taut_reg;
            m2_u_reg    <= m1_u_reg;
            m2_rel_reg  <= rel_sum[SW-1:F];
            m2_sp_reg   <= m1_sp_reg[SPW-1:F];

            m3_taut_reg <= m2_taut_reg;
            m3_u_reg    <= m2_u_reg;
            m3_sp_reg   <= m2_sp_reg;
            m3_dp_reg   <= DPW'(signed'({1'b0, damp_reg})) * DPW'(m2_rel_reg);

            m4_taut_reg <= m3_taut_reg;
            m4_u_reg    <= m3_u_reg;
            m4_t_reg    <= t_next;

            m5_taut_reg <= m4_taut_reg;
            m5_t_reg    <= m4_t_reg;
            for (int i = 0; i < 3; i++)
                m5_fp_reg[i] <= FPW'(m4_u_reg[i]) * FPW'(signed'({1'b0, m4_t_reg}));

            out_data_reg.force_a_x <= m5_fp_reg[0][F+31:F];
            out_data_reg.force_a_y <= m5_fp_reg[1][F+31:F];
            out_data_reg.force_a_z <= m5_fp_reg[2][F+31:F];
            out_data_reg.tension   <= m5_t_reg;
            out_data_reg.taut      <= m5_taut_reg;
        end
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.data  = out_data_reg;

    // ---------------- assertions ----------------
    a_slack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.data.taut |->
            out_ch.data.tension == '0 && out_ch.data.force_a_x == '0 &&
            out_ch.data.force_a_y == '0 && out_ch.data.force_a_z == '0)
        else $error("slack result carries nonzero force");

    a_no_tension_no_force: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.tension == '0 |->
            out_ch.data.force_a_x == '0 && out_ch.data.force_a_y == '0 &&
            out_ch.data.force_a_z == '0)
        else $error("force without tension");

    a_taut_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.taut |-> enable_reg)
        else $error("taut result while disabled");

endmodule
